/* sv/pte_pkg.sv */
// ----------------------------------------------------------------------------
// Permutation table engine: shared types and constants
// Command codes, status codes, request queue sizing and the request record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pte_pkg;

   // Default table capacity
   localparam int MAX_ORDER_DEF = 32;

   // Port field widths
   localparam int CMD_W    = 3;
   localparam int OPER_A_W = 6;
   localparam int OPER_B_W = 5;
   localparam int VALUE_W  = 6;
   localparam int SWAP_W   = 5;
   localparam int STATUS_W = 2;

   // Swap pairs kept per schedule request
   localparam int MAX_RESULTS = 31;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Request queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESIZE     = 3'd0,
      CMD_SWAP_ROWS  = 3'd1,
      CMD_SWAP_COLS  = 3'd2,
      CMD_COL_OF_ROW = 3'd3,
      CMD_ROW_OF_COL = 3'd4,
      CMD_IDENT      = 3'd5,
      CMD_SCHED_ROW  = 3'd6,
      CMD_SCHED_COL  = 3'd7
   } cmd_type;

   // Classified request as held in the queue
   typedef struct packed {
      cmd_type               cmd;
      logic [OPER_A_W-1:0]   oper_a;
      logic [OPER_B_W-1:0]   oper_b;
      logic                  too_big;
   } req_type;

endpackage

/* sv/pte_front.sv */
// ----------------------------------------------------------------------------
// Permutation table engine: front end
// Accepts requests, decodes the command and flags an oversized resize, and
// holds classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module pte_front
   import pte_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [OPER_A_W-1:0] req_operand_a,
   input  logic [OPER_B_W-1:0] req_operand_b,
   input  logic                q_pop,
   output logic                q_valid,
   output req_type             q_head
);

   localparam int CMP_W = OPER_A_W + 1;

   req_type             q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   req_type             entry;

   // Classify the incoming request
   always_comb begin
      entry.cmd     = cmd_type'(req_command);
      entry.oper_a  = req_operand_a;
      entry.oper_b  = req_operand_b;
      entry.too_big = {1'b0, req_operand_a} > CMP_W'(MAX_ORDER);
   end

   assign busy    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_head  = q_mem_ff[rptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = push  ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = q_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wptr_ff] <= entry;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue occupancy did not grow on push");

endmodule

/* sv/pte_back.sv */
// ----------------------------------------------------------------------------
// Permutation table engine: back end
// Holds the column table and carries out queued requests: resize, swaps,
// lookups, identity test and the cycle-following swap schedules.
// ----------------------------------------------------------------------------
module pte_back
   import pte_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  req_type             q_head,
   output logic                q_pop,
   output logic                rsp_strobe,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_is_identity,
   output logic                rsp_swap_valid,
   output logic [SWAP_W-1:0]   rsp_swap_first,
   output logic [SWAP_W-1:0]   rsp_swap_second,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int IW = $clog2(MAX_ORDER);
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam int CW = (OW > OPER_A_W) ? OW : OPER_A_W;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'h0001,
      ST_DISP   = 13'h0002,
      ST_SR_B   = 13'h0004,
      ST_SR_W1  = 13'h0008,
      ST_SR_W2  = 13'h0010,
      ST_LOOKUP = 13'h0020,
      ST_SCAN   = 13'h0040,
      ST_SC_W1  = 13'h0080,
      ST_SC_W2  = 13'h0100,
      ST_REPLY  = 13'h0200,
      ST_ADV    = 13'h0400,
      ST_NXT    = 13'h0800,
      ST_VIS    = 13'h1000
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic                is_identity;
      logic                swap_valid;
      logic [SWAP_W-1:0]   swap_first;
      logic [SWAP_W-1:0]   swap_second;
      logic                last;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [VALUE_W-1:0] v, input logic sv,
                                        input logic [SWAP_W-1:0] f,
                                        input logic [SWAP_W-1:0] s, input logic l,
                                        input logic [STATUS_W-1:0] st, input logic id);
      rsp_type r;
      r.value       = v;
      r.is_identity = id;
      r.swap_valid  = sv;
      r.swap_first  = f;
      r.swap_second = s;
      r.last        = l;
      r.status      = st;
      return r;
   endfunction

   // Control state
   state_type            state_ff, state_in;
   logic [OW-1:0]        order_ff, order_in;
   logic [MAX_ORDER-1:0] valid_ff, valid_in;
   logic [MAX_ORDER-1:0] mm_ff, mm_in;
   logic [MAX_ORDER-1:0] visited_ff, visited_in;
   logic [MAX_ORDER-1:0] ivld_ff, ivld_in;
   logic                 dv_ff, dv_in;
   logic                 fa_ff, fa_in, fb_ff, fb_in;
   logic                 pend_v_ff, pend_v_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   // Working registers
   cmd_type              cmd_ff, cmd_in;
   logic [OPER_A_W-1:0]  a_ff, a_in;
   logic [OPER_B_W-1:0]  b_ff, b_in;
   logic                 big_ff, big_in;
   logic [OW-1:0]        iss_ff, iss_in;
   logic [IW-1:0]        didx_ff, didx_in;
   logic [IW-1:0]        ra_ff, ra_in, rb_ff, rb_in;
   logic [IW-1:0]        ta_ff, ta_in;
   logic [OW-1:0]        pos_ff, pos_in;
   logic [IW-1:0]        nxt_ff, nxt_in;
   logic [IW-1:0]        pf_ff, pf_in, ps_ff, ps_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   rsp_type              rsp_ff, rsp_in;

   // Table and inverse memories with registered reads
   logic [IW-1:0]        mem [MAX_ORDER];
   logic [IW-1:0]        inv_mem [MAX_ORDER];
   logic [IW-1:0]        mem_rd_ff, inv_rd_ff, raddr_ff;
   logic                 vld_rd_ff;
   logic [IW-1:0]        rd_addr;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr, wr_data;
   logic                 inv_wr;

   // Combinational helpers
   logic [IW-1:0]        rd_val;
   logic [CW-1:0]        a_ext, b_ext, order_ext, val_ext, nxt_w;
   logic                 a_ok, b_ok, ident, didx_last, ma, mb;
   logic [MAX_ORDER-1:0] low_mask, grow_mask;
   logic [IW-1:0]        vis_idx, ivld_idx;
   logic                 vis_sel, ivld_sel;

   assign rd_val    = vld_rd_ff ? mem_rd_ff : raddr_ff;
   assign a_ext     = CW'(a_ff);
   assign b_ext     = CW'(b_ff);
   assign order_ext = CW'(order_ff);
   assign val_ext   = CW'(rd_val);
   assign a_ok      = a_ext < order_ext;
   assign b_ok      = b_ext < order_ext;
   assign didx_last = CW'(didx_ff) == (order_ext - CW'(1));
   assign ma        = val_ext == a_ext;
   assign mb        = val_ext == b_ext;

   // Rows below the order, and rows that a resize brings back to identity
   always_comb begin
      for (int i = 0; i < MAX_ORDER; i++) begin
         low_mask[i]  = CW'(i) < order_ext;
         grow_mask[i] = (CW'(i) >= order_ext) && (CW'(i) < a_ext);
      end
   end

   assign ident = ~|(mm_ff & low_mask);

   // Single read index for visited marks and inverse valid bits
   assign vis_idx  = (state_ff == ST_VIS) ? nxt_ff : IW'(pos_ff);
   assign vis_sel  = visited_ff[vis_idx];
   assign ivld_idx = (state_ff == ST_SCAN) ? rd_val : IW'(pos_ff);
   assign ivld_sel = ivld_ff[ivld_idx];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      valid_in      = valid_ff;
      mm_in         = mm_ff;
      visited_in    = visited_ff;
      ivld_in       = ivld_ff;
      dv_in         = 1'b0;
      fa_in         = fa_ff;
      fb_in         = fb_ff;
      pend_v_in     = pend_v_ff;
      rsp_strobe_in = 1'b0;
      cmd_in        = cmd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      big_in        = big_ff;
      iss_in        = iss_ff;
      didx_in       = didx_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      ta_in         = ta_ff;
      pos_in        = pos_ff;
      nxt_in        = nxt_ff;
      pf_in         = pf_ff;
      ps_in         = ps_ff;
      cnt_in        = cnt_ff;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      inv_wr        = 1'b0;
      nxt_w         = '0;

      case (state_ff)
         ST_IDLE: begin
            // Take the next queued request
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head.cmd;
               a_in     = q_head.oper_a;
               b_in     = q_head.oper_b;
               big_in   = q_head.too_big;
               state_in = ST_DISP;
            end
         end

         ST_DISP: begin
            case (cmd_ff)
               CMD_RESIZE: begin
                  if (big_ff) begin
                     rsp_in        = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_SIZE, ident);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     order_in = OW'(a_ff);
                     valid_in = valid_ff & ~grow_mask;
                     mm_in    = mm_ff & ~grow_mask;
                     state_in = ST_REPLY;
                  end
               end
               CMD_SWAP_ROWS: begin
                  if (!(a_ok && b_ok)) begin
                     rsp_in        = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_RANGE, ident);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     rd_addr  = IW'(a_ff);
                     state_in = ST_SR_B;
                  end
               end
               CMD_SWAP_COLS, CMD_ROW_OF_COL: begin
                  if (!a_ok || (cmd_ff == CMD_SWAP_COLS && !b_ok)) begin
                     rsp_in = make_rsp((cmd_ff == CMD_ROW_OF_COL) ? VALUE_W'(order_ff) : '0,
                                       1'b0, '0, '0, 1'b1, STATUS_RANGE, ident);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     iss_in   = '0;
                     fa_in    = 1'b0;
                     fb_in    = 1'b0;
                     ra_in    = '0;
                     rb_in    = '0;
                     state_in = ST_SCAN;
                  end
               end
               CMD_COL_OF_ROW: begin
                  if (!a_ok) begin
                     rsp_in        = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_RANGE, ident);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     rd_addr  = IW'(a_ff);
                     state_in = ST_LOOKUP;
                  end
               end
               CMD_IDENT: begin
                  rsp_in        = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_OK, ident);
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               CMD_SCHED_ROW: begin
                  visited_in = '0;
                  pos_in     = '0;
                  cnt_in     = '0;
                  pend_v_in  = 1'b0;
                  state_in   = ST_ADV;
               end
               CMD_SCHED_COL: begin
                  // Build the inverse table first, unless the order is empty
                  visited_in = '0;
                  ivld_in    = '0;
                  pos_in     = '0;
                  cnt_in     = '0;
                  pend_v_in  = 1'b0;
                  iss_in     = '0;
                  state_in   = (order_ff == '0) ? ST_ADV : ST_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SR_B: begin
            // Hold the first row's entry, fetch the second
            ta_in    = rd_val;
            rd_addr  = IW'(b_ff);
            state_in = ST_SR_W1;
         end

         ST_SR_W1: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(a_ff);
            wr_data  = rd_val;
            state_in = ST_SR_W2;
         end

         ST_SR_W2: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(b_ff);
            wr_data  = ta_ff;
            state_in = ST_REPLY;
         end

         ST_LOOKUP: begin
            rsp_in        = make_rsp(VALUE_W'(rd_val), 1'b0, '0, '0, 1'b1, STATUS_OK, ident);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_SCAN: begin
            // Issue one read per cycle, process the entry fetched last cycle
            if (iss_ff < order_ff) begin
               rd_addr = IW'(iss_ff);
               dv_in   = 1'b1;
               didx_in = IW'(iss_ff);
               iss_in  = iss_ff + OW'(1);
            end
            if (dv_ff) begin
               case (cmd_ff)
                  CMD_SWAP_COLS: begin
                     fa_in = fa_ff | ma;
                     fb_in = fb_ff | mb;
                     ra_in = ma ? didx_ff : ra_ff;
                     rb_in = mb ? didx_ff : rb_ff;
                     if ((fa_ff | ma) && (fb_ff | mb)) begin
                        state_in = ST_SC_W1;
                     end else if (didx_last) begin
                        rsp_in = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_RANGE, ident);
                        rsp_strobe_in = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end
                  CMD_ROW_OF_COL: begin
                     if (ma) begin
                        rsp_in = make_rsp(VALUE_W'(didx_ff), 1'b0, '0, '0, 1'b1,
                                          STATUS_OK, ident);
                        rsp_strobe_in = 1'b1;
                        state_in      = ST_IDLE;
                     end else if (didx_last) begin
                        rsp_in = make_rsp(VALUE_W'(order_ff), 1'b0, '0, '0, 1'b1,
                                          STATUS_OK, ident);
                        rsp_strobe_in = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end
                  default: begin
                     // First row holding a column wins
                     if ((val_ext < order_ext) && !ivld_sel) begin
                        inv_wr = 1'b1;
                     end
                     if (didx_last) begin
                        state_in = ST_ADV;
                     end
                  end
               endcase
            end
         end

         ST_SC_W1: begin
            wr_en    = 1'b1;
            wr_addr  = rb_ff;
            wr_data  = IW'(a_ff);
            state_in = ST_SC_W2;
         end

         ST_SC_W2: begin
            wr_en    = 1'b1;
            wr_addr  = ra_ff;
            wr_data  = IW'(b_ff);
            state_in = ST_REPLY;
         end

         ST_REPLY: begin
            rsp_in        = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_OK, ident);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_ADV: begin
            // Skip visited entries; flush the held pair when the walk ends
            rd_addr = IW'(pos_ff);
            if (pos_ff >= order_ff) begin
               if (pend_v_ff) begin
                  rsp_in = make_rsp('0, 1'b1, SWAP_W'(pf_ff), SWAP_W'(ps_ff), 1'b1,
                                    STATUS_OK, ident);
               end else begin
                  rsp_in = make_rsp('0, 1'b0, '0, '0, 1'b1, STATUS_OK, ident);
               end
               rsp_strobe_in = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = ST_IDLE;
            end else if (vis_sel) begin
               pos_in = pos_ff + OW'(1);
            end else begin
               state_in = ST_NXT;
            end
         end

         ST_NXT: begin
            if (cmd_ff == CMD_SCHED_COL) begin
               nxt_w = ivld_sel ? CW'(inv_rd_ff) : order_ext;
            end else begin
               nxt_w = val_ext;
            end
            visited_in[IW'(pos_ff)] = 1'b1;
            if (nxt_w >= order_ext) begin
               state_in = ST_ADV;
            end else begin
               nxt_in   = IW'(nxt_w);
               state_in = ST_VIS;
            end
         end

         ST_VIS: begin
            // Emit the held pair and hold the new one, so the final pair gets last
            if (!vis_sel && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
               if (pend_v_ff) begin
                  rsp_in = make_rsp('0, 1'b1, SWAP_W'(pf_ff), SWAP_W'(ps_ff), 1'b0,
                                    STATUS_OK, ident);
                  rsp_strobe_in = 1'b1;
               end
               pf_in     = IW'(pos_ff);
               ps_in     = nxt_ff;
               pend_v_in = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
            pos_in   = OW'(nxt_ff);
            state_in = ST_ADV;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Track written entries and their mismatch against identity
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         mm_in[wr_addr]    = (wr_data != wr_addr);
      end
      if (inv_wr) begin
         ivld_in[rd_val] = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         order_ff      <= OW'(MAX_ORDER);
         valid_ff      <= '0;
         mm_ff         <= '0;
         visited_ff    <= '0;
         ivld_ff       <= '0;
         dv_ff         <= 1'b0;
         fa_ff         <= 1'b0;
         fb_ff         <= 1'b0;
         pend_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         order_ff      <= order_in;
         valid_ff      <= valid_in;
         mm_ff         <= mm_in;
         visited_ff    <= visited_in;
         ivld_ff       <= ivld_in;
         dv_ff         <= dv_in;
         fa_ff         <= fa_in;
         fb_ff         <= fb_in;
         pend_v_ff     <= pend_v_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      big_ff  <= big_in;
      iss_ff  <= iss_in;
      didx_ff <= didx_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      ta_ff   <= ta_in;
      pos_ff  <= pos_in;
      nxt_ff  <= nxt_in;
      pf_ff   <= pf_in;
      ps_ff   <= ps_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   // Table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[rd_addr];
      vld_rd_ff <= valid_ff[rd_addr];
      raddr_ff  <= rd_addr;
   end

   // Inverse memory for the column schedule
   always_ff @(posedge clock) begin
      if (inv_wr) begin
         inv_mem[rd_val] <= didx_ff;
      end
      inv_rd_ff <= inv_mem[rd_addr];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_value       = rsp_ff.value;
   assign rsp_is_identity = rsp_ff.is_identity;
   assign rsp_swap_valid  = rsp_ff.swap_valid;
   assign rsp_swap_first  = rsp_ff.swap_first;
   assign rsp_swap_second = rsp_ff.swap_second;
   assign rsp_last        = rsp_ff.last;
   assign rsp_status      = rsp_ff.status;

   a_order_bound : assert property (@(posedge clock) disable iff (reset)
      order_ff <= OW'(MAX_ORDER))
      else $error("order beyond capacity");

   a_mismatch_written : assert property (@(posedge clock) disable iff (reset)
      (mm_ff & ~valid_ff) == '0)
      else $error("mismatch flagged on an unwritten entry");

   a_pending_in_walk : assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> (state_ff == ST_ADV || state_ff == ST_NXT || state_ff == ST_VIS))
      else $error("held swap pair outside a schedule walk");

   a_pair_status_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.swap_valid) |-> rsp_ff.status == STATUS_OK)
      else $error("swap pair with error status");

   a_scan_data : assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> $past(state_ff == ST_SCAN))
      else $error("scan data outside a scan");

endmodule

/* sv/permutation_table_engine_top.sv */
// ----------------------------------------------------------------------------
// Permutation table engine
// Keeps a permutation as a row-to-column table with an order in use, and
// answers resize, swap, lookup, identity and swap-schedule requests.
//
//   channel  ports                                  handshake
//   request  req_command, req_operand_a/_b          start high, busy low
//   result   rsp_value ... rsp_status               rsp_strobe, one cycle
//
// A request waits in the queue until the back end is idle and takes it.
// Row-of-column scans the table one entry a cycle; a column swap scans
// the same way and then writes both entries. A row schedule walks the
// table entry by entry; a column schedule first builds the inverse table.
// Reset is synchronous and restores the identity of full order at once.
// The queue holds four requests; busy is high while it is full.
// ----------------------------------------------------------------------------
module permutation_table_engine_top
   import pte_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [OPER_A_W-1:0] req_operand_a,
   input  logic [OPER_B_W-1:0] req_operand_b,
   output logic                rsp_strobe,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_is_identity,
   output logic                rsp_swap_valid,
   output logic [SWAP_W-1:0]   rsp_swap_first,
   output logic [SWAP_W-1:0]   rsp_swap_second,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status
);

   logic    q_pop;
   logic    q_valid;
   req_type q_head;

   // Accept and classify requests
   pte_front #(
      .MAX_ORDER (MAX_ORDER)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .q_pop         (q_pop),
      .q_valid       (q_valid),
      .q_head        (q_head)
   );

   // Carry out requests on the table
   pte_back #(
      .MAX_ORDER (MAX_ORDER)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value),
      .rsp_is_identity (rsp_is_identity),
      .rsp_swap_valid  (rsp_swap_valid),
      .rsp_swap_first  (rsp_swap_first),
      .rsp_swap_second (rsp_swap_second),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

endmodule
